FILE: hw/rtl/ple_pkg.sv
// Shared types and constants of the positional list engine.
package ple_pkg;

   localparam int FUNC_W      = 3;
   localparam int VALUE_W     = 32;
   localparam int POS_W       = 6;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 6;
   localparam int ELEM_W      = 32;

   localparam int PLE_CAPACITY   = 32;
   localparam int PLE_DATA_WIDTH = 32;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INS_FRONT = 3'd0,
      FUNC_INS_BACK  = 3'd1,
      FUNC_INS_AT    = 3'd2,
      FUNC_DEL_FRONT = 3'd3,
      FUNC_DEL_BACK  = 3'd4,
      FUNC_DEL_AT    = 3'd5,
      FUNC_READ_OUT  = 3'd6
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_BADPOS = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_INS_RD,
      S_INS_WR,
      S_INS_NEW,
      S_DEL_RD,
      S_DEL_WR,
      S_RO_ADDR,
      S_RO_DATA,
      S_RESP
   } state_type;

   typedef enum logic [1:0] {
      KIND_RESP,
      KIND_INS,
      KIND_DEL,
      KIND_RO
   } kind_type;

   typedef enum logic {
      STEP_INC,
      STEP_DEC
   } step_mode_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_cmd_type;

   typedef struct packed {
      logic       load;
      status_type status;
      logic       last;
      logic       with_elem;
   } rsp_load_type;

endpackage

FILE: hw/rtl/ple_list_mem.sv
// Entry storage of the list: one write port and one registered read port.
module ple_list_mem
   import ple_pkg::*;
#(
   parameter int DEPTH = PLE_CAPACITY,
   parameter int AW    = $clog2(PLE_CAPACITY),
   parameter int DW    = PLE_DATA_WIDTH
) (
   input  logic          clock,
   input  mem_cmd_type   cmd,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] slots_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         slots_ff[wr_addr] <= wr_data;
      end
   end

   // Read data holds until the next read, so a stalled result keeps its word.
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= slots_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/ple_step_unit.sv
// Shared index unit: steps the walk index by one and tests for the end of the walk.
module ple_step_unit
   import ple_pkg::*;
#(
   parameter int AW = $clog2(PLE_CAPACITY),
   parameter int CW = $clog2(PLE_CAPACITY + 1)
) (
   input  step_mode_type mode,
   input  logic [AW-1:0] cur,
   input  logic [AW-1:0] idx,
   input  logic [CW-1:0] cnt,
   output logic [AW-1:0] nxt,
   output logic          hit
);

   logic [AW:0] sum;

   always_comb begin
      if (mode == STEP_INC) begin
         sum = {1'b0, cur} + (AW+1)'(1);
         hit = (sum == (AW+1)'(cnt));
      end else begin
         sum = {1'b0, cur} - (AW+1)'(1);
         hit = (cur == idx);
      end
      nxt = sum[AW-1:0];
   end

endmodule

FILE: hw/rtl/ple_seq.sv
// Sequencer of the list engine: decodes an operation and walks the entries.
module ple_seq
   import ple_pkg::*;
#(
   parameter int CAPACITY   = PLE_CAPACITY,
   parameter int DATA_WIDTH = PLE_DATA_WIDTH,
   parameter int AW         = $clog2(PLE_CAPACITY),
   parameter int CW         = $clog2(PLE_CAPACITY + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [FUNC_W-1:0]     req_func,
   input  logic [DATA_WIDTH-1:0] req_word,
   input  logic [POS_W-1:0]      req_position,
   input  logic                  out_free,
   output step_mode_type         step_mode,
   output logic [AW-1:0]         step_cur,
   output logic [AW-1:0]         step_idx,
   output logic [CW-1:0]         step_cnt,
   input  logic [AW-1:0]         step_nxt,
   input  logic                  step_hit,
   output mem_cmd_type           mem_cmd,
   output logic [AW-1:0]         mem_wr_addr,
   output logic [DATA_WIDTH-1:0] mem_wr_data,
   output logic [AW-1:0]         mem_rd_addr,
   input  logic [DATA_WIDTH-1:0] mem_rd_data,
   output rsp_load_type          rsp_load,
   output logic [CW-1:0]         rsp_cnt
);

   localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

   state_type             state_ff, state_in;
   func_type              func_ff;
   logic [DATA_WIDTH-1:0] word_ff;
   logic [POS_W-1:0]      pos_ff;
   logic [CW-1:0]         count_ff, count_in;
   logic [AW-1:0]         i_ff, i_in;
   logic [AW-1:0]         idx_ff, idx_in;
   status_type            st_ff, st_in;

   kind_type              dec_kind;
   status_type            dec_status;
   logic [AW-1:0]         dec_idx;
   logic [AW-1:0]         dec_start;
   logic [CMPW-1:0]       pos_x, cnt_x;
   logic                  full, empty;
   logic [AW-1:0]         cnt_a, pos_a, last_a;

   // Operation decode, evaluated from the captured request.
   always_comb begin
      pos_x      = CMPW'(pos_ff);
      cnt_x      = CMPW'(count_ff);
      full       = (count_ff == CW'(CAPACITY));
      empty      = (count_ff == '0);
      cnt_a      = AW'(count_ff);
      pos_a      = AW'(pos_ff - POS_W'(1));
      last_a     = AW'(count_ff - CW'(1));
      dec_kind   = KIND_RESP;
      dec_status = ST_OK;
      dec_idx    = '0;
      unique case (func_ff)
         FUNC_INS_FRONT: begin
            if (full) dec_status = ST_FULL;
            else dec_kind = KIND_INS;
         end
         FUNC_INS_BACK: begin
            dec_idx = cnt_a;
            if (full) dec_status = ST_FULL;
            else dec_kind = KIND_INS;
         end
         FUNC_INS_AT: begin
            dec_idx = pos_a;
            if (pos_x == '0 || pos_x > cnt_x + CMPW'(1)) dec_status = ST_BADPOS;
            else if (full) dec_status = ST_FULL;
            else dec_kind = KIND_INS;
         end
         FUNC_DEL_FRONT: begin
            if (empty) dec_status = ST_EMPTY;
            else dec_kind = KIND_DEL;
         end
         FUNC_DEL_BACK: begin
            dec_idx = last_a;
            if (empty) dec_status = ST_EMPTY;
            else dec_kind = KIND_DEL;
         end
         FUNC_DEL_AT: begin
            dec_idx = pos_a;
            if (pos_x == '0 || pos_x > cnt_x) dec_status = ST_BADPOS;
            else dec_kind = KIND_DEL;
         end
         FUNC_READ_OUT: begin
            if (empty) dec_status = ST_EMPTY;
            else dec_kind = KIND_RO;
         end
         default: begin
            dec_kind = KIND_RESP;
         end
      endcase
      unique case (dec_kind)
         KIND_INS: dec_start = cnt_a;
         KIND_DEL: dec_start = dec_idx;
         default:  dec_start = '0;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (req_valid) state_in = S_DECODE;
         S_DECODE: begin
            unique case (dec_kind)
               KIND_INS: state_in = S_INS_RD;
               KIND_DEL: state_in = S_DEL_RD;
               KIND_RO:  state_in = S_RO_ADDR;
               default:  state_in = S_RESP;
            endcase
         end
         S_INS_RD:  state_in = step_hit ? S_INS_NEW : S_INS_WR;
         S_INS_WR:  state_in = S_INS_RD;
         S_INS_NEW: state_in = S_RESP;
         S_DEL_RD:  state_in = step_hit ? S_RESP : S_DEL_WR;
         S_DEL_WR:  state_in = S_DEL_RD;
         S_RO_ADDR: state_in = S_RO_DATA;
         S_RO_DATA: if (out_free) state_in = step_hit ? S_IDLE : S_RO_ADDR;
         S_RESP:    if (out_free) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // Outputs and datapath updates.
   always_comb begin
      mem_cmd     = '0;
      mem_wr_addr = i_ff;
      mem_wr_data = mem_rd_data;
      mem_rd_addr = step_nxt;
      i_in        = i_ff;
      idx_in      = idx_ff;
      count_in    = count_ff;
      st_in       = st_ff;
      rsp_load    = '{load: 1'b0, status: ST_OK, last: 1'b1, with_elem: 1'b0};
      step_mode   = STEP_INC;
      unique case (state_ff)
         S_DECODE: begin
            st_in  = dec_status;
            idx_in = dec_idx;
            i_in   = dec_start;
         end
         S_INS_RD: begin
            step_mode     = STEP_DEC;
            mem_cmd.rd_en = !step_hit;
         end
         S_INS_WR: begin
            step_mode     = STEP_DEC;
            mem_cmd.wr_en = 1'b1;
            i_in          = step_nxt;
         end
         S_INS_NEW: begin
            mem_cmd.wr_en = 1'b1;
            mem_wr_addr   = idx_ff;
            mem_wr_data   = word_ff;
            count_in      = count_ff + CW'(1);
         end
         S_DEL_RD: begin
            if (step_hit) count_in = count_ff - CW'(1);
            else mem_cmd.rd_en = 1'b1;
         end
         S_DEL_WR: begin
            mem_cmd.wr_en = 1'b1;
            i_in          = step_nxt;
         end
         S_RO_ADDR: begin
            mem_cmd.rd_en = 1'b1;
            mem_rd_addr   = i_ff;
         end
         S_RO_DATA: begin
            if (out_free) begin
               rsp_load = '{load: 1'b1, status: ST_OK, last: step_hit, with_elem: 1'b1};
               i_in     = step_nxt;
            end
         end
         S_RESP: begin
            if (out_free) begin
               rsp_load = '{load: 1'b1, status: st_ff, last: 1'b1, with_elem: 1'b0};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         func_ff <= func_type'(req_func);
         word_ff <= req_word;
         pos_ff  <= req_position;
      end
      i_ff   <= i_in;
      idx_ff <= idx_in;
      st_ff  <= st_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign step_cur  = i_ff;
   assign step_idx  = idx_ff;
   assign step_cnt  = count_ff;
   assign rsp_cnt   = count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == S_DECODE)
      else $error("accepted transaction not decoded");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load.load |-> out_free)
      else $error("result loaded over a pending result");

   a_one_port: assert property (@(posedge clock) disable iff (reset)
      !(mem_cmd.wr_en && mem_cmd.rd_en))
      else $error("memory read and write in the same cycle");

   a_ins_room: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INS_NEW |-> !full)
      else $error("insert into a full list");

endmodule

FILE: hw/rtl/positional_list_engine.sv
// Top level of the positional list engine: an ordered list with positional edits.
//
//   channel   prefix  direction  payload
//   request   req_    in         func, value, position
//   response  rsp_    out        status, count, element, last
//
// One transaction is taken at a time; req_ready is high only while the sequencer is idle.
// Insert and delete shift every moved entry with a read state and a write state, and
// insert then writes the new word; read-out reads each entry in an address state and a
// data state, set by the registered memory read. An operation that only reports a
// status goes from decode straight to the response state. A response register holds the result; a
// stalled rsp_ready holds the sequencer in place while it has a result to load. Reset (synchronous, active high)
// empties the list; entries need no clearing.
module positional_list_engine
   import ple_pkg::*;
#(
   parameter int CAPACITY   = PLE_CAPACITY,
   parameter int DATA_WIDTH = PLE_DATA_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [FUNC_W-1:0]      req_func,
   input  logic [VALUE_W-1:0]     req_value,
   input  logic [POS_W-1:0]       req_position,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [COUNT_OUT_W-1:0] rsp_count,
   output logic [ELEM_W-1:0]      rsp_element,
   output logic                   rsp_last
);

   // Address width of the entry memory and width of the entry counter.
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic [DATA_WIDTH-1:0] req_word;
   logic                  out_free;
   step_mode_type         step_mode;
   logic [AW-1:0]         step_cur, step_idx, step_nxt;
   logic [CW-1:0]         step_cnt;
   logic                  step_hit;
   mem_cmd_type           mem_cmd;
   logic [AW-1:0]         mem_wr_addr, mem_rd_addr;
   logic [DATA_WIDTH-1:0] mem_wr_data, mem_rd_data;
   rsp_load_type          rsp_load;
   logic [CW-1:0]         rsp_cnt;

   logic                   rsp_valid_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [COUNT_OUT_W-1:0] rsp_count_ff;
   logic [ELEM_W-1:0]      rsp_element_ff;
   logic                   rsp_last_ff;

   // Stored words keep DATA_WIDTH bits of the incoming value.
   assign req_word = DATA_WIDTH'(req_value);

   // The response register can take a new result when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;

   ple_seq #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH),
      .AW         (AW),
      .CW         (CW)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_word     (req_word),
      .req_position (req_position),
      .out_free     (out_free),
      .step_mode    (step_mode),
      .step_cur     (step_cur),
      .step_idx     (step_idx),
      .step_cnt     (step_cnt),
      .step_nxt     (step_nxt),
      .step_hit     (step_hit),
      .mem_cmd      (mem_cmd),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data),
      .mem_rd_addr  (mem_rd_addr),
      .mem_rd_data  (mem_rd_data),
      .rsp_load     (rsp_load),
      .rsp_cnt      (rsp_cnt)
   );

   // The one index unit serves shifting walks in both directions and read-out.
   ple_step_unit #(
      .AW (AW),
      .CW (CW)
   ) u_step (
      .mode (step_mode),
      .cur  (step_cur),
      .idx  (step_idx),
      .cnt  (step_cnt),
      .nxt  (step_nxt),
      .hit  (step_hit)
   );

   ple_list_mem #(
      .DEPTH (CAPACITY),
      .AW    (AW),
      .DW    (DATA_WIDTH)
   ) u_mem (
      .clock   (clock),
      .cmd     (mem_cmd),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Response register. The count is reported modulo the field width, and the element
   // field shows the low bits of the stored word, zero outside read-out.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load.load) begin
         rsp_status_ff  <= rsp_load.status;
         rsp_count_ff   <= COUNT_OUT_W'(rsp_cnt);
         rsp_element_ff <= rsp_load.with_elem ? ELEM_W'(mem_rd_data) : '0;
         rsp_last_ff    <= rsp_load.last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_count   = rsp_count_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_last    = rsp_last_ff;

endmodule
